[rtl/bitmap_slot_allocator_core_defines.svh]
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BSA_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("slot allocator assertion failed in %m");

// Next-cycle implication, checked at every rising edge outside reset.
`define BSA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("slot allocator assertion failed in %m");

`endif

[rtl/bsa_pkg.sv]
// Package: shared types and constants of the bitmap slot allocator.
`default_nettype none
package bsa_pkg;

  localparam int PAGE_W             = 4;
  localparam int SLOT_W             = 6;
  localparam int STATUS_W           = 2;
  localparam int NUM_PAGES_DEF      = 16;
  localparam int SLOTS_PER_PAGE_DEF = 63;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_SLOT = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

  // Queue update requested for one beat.
  typedef struct packed {
    logic pop;
    logic push;
  } queue_op_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage
`default_nettype wire

[rtl/bitmap_slot_allocator_core.sv]
// Top level of the bitmap slot allocator: input register, allocate/free logic, result register.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid, in_stall | command, free_page, free_slot
//   out     | out_valid, out_stall | status, granted_page, granted_slot
//
// Flow: one beat in and one result out per cycle while out_stall does not hold the result
//   register. A beat accepted into the input register has its result written to the result
//   register when it advances; in between, the bitmap read, the find-first-set over
//   one page bitmap and the queue update are worked out combinationally.
// Reset: rst clears all page bitmaps to all free and refills the page queue with
//   every page in order at once; the first beat may be accepted straight after.
// Stalls: out_stall holds the result register; in_stall rises only while the input
//   register is full and its result cannot move on.
`default_nettype none
`include "bitmap_slot_allocator_core_defines.svh"
module bitmap_slot_allocator_core
  import bsa_pkg::*;
#(
  parameter int NUM_PAGES      = NUM_PAGES_DEF,
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [PAGE_W-1:0]   free_page,
  input  logic [SLOT_W-1:0]   free_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [PAGE_W-1:0]   granted_page,
  output logic [SLOT_W-1:0]   granted_slot
);

  localparam int PW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW  = SLOTS_PER_PAGE;
  localparam int SIW = (SW > 1) ? $clog2(SW) : 1;
  // Wide enough for both the port page and NUM_PAGES itself.
  localparam int CW  = ((PW > PAGE_W) ? PW : PAGE_W) + 1;

  // Input register.
  logic              held_valid;
  cmd_t              held_cmd;
  logic [PAGE_W-1:0] held_page;
  logic [SLOT_W-1:0] held_slot;

  logic out_free;
  logic advance;

  // Datapath.
  logic [CW-1:0]  page_ext;
  logic           page_bad;
  logic           slot_bad;
  logic [PW-1:0]  free_idx;
  logic [PW-1:0]  head_page;
  logic [PW-1:0]  bank_addr;
  logic [SW-1:0]  bitmap;
  logic [SW-1:0]  slot_bit;
  logic           slot_hit;
  logic           ffs_found;
  logic [SIW-1:0] ffs_idx;
  logic [SW-1:0]  ffs_cleared;
  logic           bank_wr;
  logic [SW-1:0]  bank_wdata;
  queue_op_t      q_op;
  queue_stat_t    q_stat;

  status_t           status_next;
  logic [PAGE_W-1:0] granted_page_next;
  logic [SLOT_W-1:0] granted_slot_next;

  // Handshake: advance the held beat whenever the result register can take it.
  assign out_free = !out_valid || !out_stall;
  assign advance  = held_valid && out_free;
  assign in_stall = held_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  // Payload needs no reset: hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_cmd  <= cmd_t'(command);
      held_page <= free_page;
      held_slot <= free_slot;
    end
  end

  // Range checks on the free request.
  assign page_ext = CW'(held_page);
  assign page_bad = (page_ext >= CW'(NUM_PAGES));
  assign slot_bad = (held_slot >= SLOT_W'(SLOTS_PER_PAGE));
  assign free_idx = page_ext[PW-1:0];

  // One bitmap read per beat: the head page on allocate, the named page on free.
  assign bank_addr = (held_cmd == CMD_FREE) ? free_idx : head_page;
  assign slot_bit  = SW'(1) << held_slot;
  assign slot_hit  = |(bitmap & slot_bit);

  bsa_bitmap_bank #(
    .NUM_PAGES      (NUM_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .addr    (bank_addr),
    .rd_data (bitmap),
    .wr_en   (bank_wr),
    .wr_data (bank_wdata)
  );

  bsa_ffs #(
    .W (SW)
  ) u_ffs (
    .vec     (bitmap),
    .found   (ffs_found),
    .idx     (ffs_idx),
    .cleared (ffs_cleared)
  );

  bsa_page_fifo #(
    .NUM_PAGES (NUM_PAGES)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .op        (q_op),
    .push_page (free_idx),
    .head_page (head_page),
    .stat      (q_stat)
  );

  // Command decode. State changes only on a beat that advances.
  always_comb begin
    status_next       = STATUS_OK;
    granted_page_next = '0;
    granted_slot_next = '0;
    bank_wr           = 1'b0;
    bank_wdata        = bitmap;
    q_op              = '0;
    unique case (held_cmd)
      CMD_ALLOC: begin
        priority if (q_stat.empty) begin
          status_next = STATUS_NO_SLOT;
        end else if (!ffs_found) begin
          // Head page found empty: drop it from the queue and report no slot.
          status_next = STATUS_NO_SLOT;
          q_op.pop    = advance;
        end else begin
          bank_wr           = advance;
          bank_wdata        = ffs_cleared;
          q_op.pop          = advance && !(|ffs_cleared);
          granted_page_next = PAGE_W'(CW'(head_page));
          granted_slot_next = SLOT_W'(ffs_idx);
        end
      end
      CMD_FREE: begin
        priority if (page_bad || slot_bad || slot_hit) begin
          status_next = STATUS_IGNORED;
        end else begin
          bank_wr    = advance;
          bank_wdata = bitmap | slot_bit;
          // A page that was full goes back at the tail.
          q_op.push  = advance && !(|bitmap) && !q_stat.full;
        end
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= STATUS_W'(status_next);
      granted_page <= granted_page_next;
      granted_slot <= granted_slot_next;
    end
  end

  `BSA_ASSERT_NEXT(a_advance_fills_result, clk, rst, advance, out_valid)
  `BSA_ASSERT_IMPL(a_grant_zero_unless_ok, clk, rst, out_valid && (status != STATUS_W'(STATUS_OK)), (granted_page == '0) && (granted_slot == '0))
  `BSA_ASSERT_IMPL(a_no_state_change_on_hold, clk, rst, !advance, !bank_wr && !q_op.pop && !q_op.push)

endmodule
`default_nettype wire

[rtl/bsa_ffs.sv]
// Find-first-set: lowest set bit of a bitmap, its index and the bitmap with it cleared.
`default_nettype none
module bsa_ffs
  import bsa_pkg::*;
#(
  parameter int W = SLOTS_PER_PAGE_DEF
) (
  input  logic [W-1:0]                      vec,
  output logic                              found,
  output logic [((W > 1) ? $clog2(W) : 1)-1:0] idx,
  output logic [W-1:0]                      cleared
);

  localparam int IW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] lsb;

  // Isolate the lowest set bit, then encode it: each index bit is an OR of one-hot bits.
  assign lsb     = vec & (~vec + W'(1));
  assign cleared = vec & (vec - W'(1));
  assign found   = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (lsb[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/bsa_bitmap_bank.sv]
// Bank of per-page free bitmaps, one read and one write port.
`default_nettype none
module bsa_bitmap_bank
  import bsa_pkg::*;
#(
  parameter int NUM_PAGES      = NUM_PAGES_DEF,
  parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic [((NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1)-1:0] addr,
  output logic [SLOTS_PER_PAGE-1:0]                        rd_data,
  input  logic                                             wr_en,
  input  logic [SLOTS_PER_PAGE-1:0]                        wr_data
);

  logic [SLOTS_PER_PAGE-1:0] bitmaps [NUM_PAGES];

  assign rd_data = bitmaps[addr];

  // Every slot starts free.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        bitmaps[i] <= '1;
      end
    end else if (wr_en) begin
      bitmaps[addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[rtl/bsa_page_fifo.sv]
// Circular queue of pages that still hold free slots; its head is the current page.
`default_nettype none
`include "bitmap_slot_allocator_core_defines.svh"
module bsa_page_fifo
  import bsa_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  queue_op_t                                        op,
  input  logic [((NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1)-1:0] push_page,
  output logic [((NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1)-1:0] head_page,
  output queue_stat_t                                      stat
);

  localparam int PW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int CNTW = $clog2(NUM_PAGES + 1);
  localparam int SUMW = PW + 1;

  logic [PW-1:0]   entries [NUM_PAGES];
  logic [PW-1:0]   head;
  logic [CNTW-1:0] count;
  logic [PW-1:0]   head_next;
  logic [SUMW-1:0] tail_sum;
  logic [PW-1:0]   tail;

  assign head_page  = entries[head];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNTW'(NUM_PAGES));

  assign head_next = (head == PW'(NUM_PAGES - 1)) ? '0 : head + PW'(1);
  // head + count stays below twice the depth: one compare and subtract wraps it.
  assign tail_sum  = SUMW'(head) + SUMW'(count);
  assign tail      = (tail_sum >= SUMW'(NUM_PAGES)) ?
                     PW'(tail_sum - SUMW'(NUM_PAGES)) : PW'(tail_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        entries[i] <= PW'(i);
      end
      head  <= '0;
      count <= CNTW'(NUM_PAGES);
    end else begin
      if (op.pop) begin
        head  <= head_next;
        count <= count - CNTW'(1);
      end else if (op.push) begin
        entries[tail] <= push_page;
        count         <= count + CNTW'(1);
      end
    end
  end

  `BSA_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, op.pop, !stat.empty)
  `BSA_ASSERT_IMPL(a_push_only_alone_and_room, clk, rst, op.push, !op.pop && !stat.full)
  `BSA_ASSERT_NEXT(a_pop_drops_count, clk, rst, op.pop, count == $past(count) - CNTW'(1))

endmodule
`default_nettype wire
